/* hdl/pdc_pkg.sv */
package pdc_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 32;
  localparam int IDX_W      = 10;
  localparam int COUNT_W    = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      last_point;
    logic [IDX_W-1:0]          read_index;
  } pdc_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   point_index;
    logic [COUNT_W-1:0] dominated_count;
    logic               valid_res;
  } pdc_out_t;

  typedef struct packed {
    logic take_load;
    logic take_read;
    logic scan_issue;
    logic store;
    logic rd_sel_idx;
    logic out_load;
  } pdc_cmd_t;

  typedef struct packed {
    logic load_room;
    logic scan_more;
    logic scan_done;
    logic out_free;
  } pdc_status_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

/* hdl/point_dominance_counter.sv */
// Two-dimensional dominance counter. A load transfer (kind 0) stores one point.
// A sweep over the stored set then updates the new point's own count and the
// counts of the stored points it precedes. The sweep reads one entry per cycle
// through the read port of the point memories. The input stalls during the
// sweep and the store; a load taken with MAX_POINTS stored in an open set is
// dropped. A read transfer (kind 1) loads the count held for read_index into
// the result register after the count memory has been read and once that
// register is free; valid_res is 0 past the loaded count. One transfer is in
// work at a time; the result register lets a new transfer start while a
// result waits. No clearing pass is needed after reset.
module point_dominance_counter (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  pdc_pkg::pdc_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output pdc_pkg::pdc_out_t result
);
  import pdc_pkg::*;

  pdc_cmd_t    cmd;
  pdc_status_t status;

  pdc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_kind(item.kind), .item_stall(item_stall),
    .status(status), .cmd(cmd)
  );

  pdc_dp u_dp (
    .clk(clk), .rst(rst), .item(item), .cmd(cmd), .status(status),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

endmodule

/* hdl/pdc_ram.sv */
module pdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pdc_ctrl.sv */
module pdc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_kind,
  output logic                 item_stall,
  input  pdc_pkg::pdc_status_t status,
  output pdc_pkg::pdc_cmd_t    cmd
);
  import pdc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_RADDR = 3'd3;
  localparam logic [2:0] S_ROUT  = 3'd4;

  logic [2:0] state, state_next;
  logic       take;

  assign item_stall = (state != S_IDLE);
  assign take       = (state == S_IDLE) && item_valid;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.take_load  = take && (item_kind == KIND_LOAD);
    cmd.take_read  = take && (item_kind == KIND_READ);
    case (state)
      S_IDLE: begin
        if (cmd.take_read) begin
          state_next = S_RADDR;
        end else if (cmd.take_load && status.load_room) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = status.scan_more;
        if (status.scan_done) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_IDLE;
      end
      S_RADDR: begin
        cmd.rd_sel_idx = 1'b1;
        state_next     = S_ROUT;
      end
      S_ROUT: begin
        cmd.rd_sel_idx = 1'b1;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_STORE || state == S_ROUT) |-> item_stall)
    else $error("input taken while busy");
  a_store_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> $past(state) == S_SCAN)
    else $error("store without scan");
  a_read_path: assert property (@(posedge clk) disable iff (rst)
    cmd.take_read |=> state == S_RADDR ##1 state == S_ROUT)
    else $error("read sequence broken");

endmodule

/* hdl/pdc_dp.sv */
module pdc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pdc_pkg::pdc_in_t     item,
  input  pdc_pkg::pdc_cmd_t    cmd,
  output pdc_pkg::pdc_status_t status,
  output logic                 result_valid,
  input  logic                 result_stall,
  output pdc_pkg::pdc_out_t    result
);
  import pdc_pkg::*;

  logic [CNT_W-1:0]          n, i;
  logic [ADDR_W-1:0]         rd_i;
  logic                      set_complete, rd_v;
  logic signed [COORD_W-1:0] px, py;
  logic [COUNT_W-1:0]        own;
  logic [IDX_W-1:0]          idx;

  logic [ADDR_W-1:0]  raddr, xy_waddr, c_waddr;
  logic [COORD_W-1:0] q_x, q_y;
  logic [COUNT_W-1:0] q_cnt, c_wdata;
  logic               c_we, dom, prec, ok;

  assign raddr = cmd.rd_sel_idx ? ADDR_W'(idx) : i[ADDR_W-1:0];
  assign xy_waddr = n[ADDR_W-1:0];

  assign dom  = ($signed(q_x) <= px) && ($signed(q_y) <= py);
  assign prec = ((px < $signed(q_x)) && (py <= $signed(q_y))) ||
                ((px == $signed(q_x)) && (py < $signed(q_y)));

  assign c_we    = cmd.store || (rd_v && prec);
  assign c_waddr = cmd.store ? n[ADDR_W-1:0] : rd_i;
  assign c_wdata = cmd.store ? own : sat_inc(q_cnt);

  assign ok = (32'(idx) < 32'(n));

  assign status.load_room = set_complete || (32'(n) < 32'(MAX_POINTS));
  assign status.scan_more = (i < n);
  assign status.scan_done = (i == n) && !rd_v;
  assign status.out_free  = !result_valid || !result_stall;

  pdc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk(clk), .we(cmd.store), .waddr(xy_waddr), .wdata(px),
    .raddr(raddr), .rdata(q_x)
  );

  pdc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk(clk), .we(cmd.store), .waddr(xy_waddr), .wdata(py),
    .raddr(raddr), .rdata(q_y)
  );

  pdc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_POINTS)) u_cnt_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(raddr), .rdata(q_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      n            <= '0;
      set_complete <= 1'b0;
      rd_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_v <= cmd.scan_issue;
      if (cmd.take_load) begin
        set_complete <= item.last_point;
        if (set_complete) begin
          n <= '0;
        end
      end
      if (cmd.store) begin
        n <= n + 1'b1;
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_load) begin
      px  <= item.coord_x;
      py  <= item.coord_y;
      i   <= '0;
      own <= '0;
    end
    if (cmd.take_read) begin
      idx <= item.read_index;
    end
    if (cmd.scan_issue) begin
      i    <= i + 1'b1;
      rd_i <= i[ADDR_W-1:0];
    end
    if (rd_v && dom) begin
      own <= sat_inc(own);
    end
    if (cmd.out_load) begin
      result.point_index     <= idx;
      result.dominated_count <= ok ? q_cnt : '0;
      result.valid_res       <= ok;
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_issue |-> i < n)
    else $error("scan past stored points");
  a_store_count: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> n == CNT_W'($past(n) + 1'b1))
    else $error("point count not advanced");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || !result_stall))
    else $error("pending result overwritten");
  a_store_room: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> 32'(n) < 32'(MAX_POINTS))
    else $error("store beyond capacity");

endmodule
